// ===== rtl/core/sitd_pkg.sv =====
// Shared constants and controller/datapath handshake types for the integer-to-text converter.
package sitd_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int DIGIT_W    = 4;
  localparam int MAX_DIGITS = 10;
  localparam int CNT_W      = 4;
  localparam int QUOT_W     = 29;
  localparam int PROD_W     = 2 * VALUE_W;
  localparam int RECIP_SH   = 35;

  // ceil(2^35 / 10): the product shifted right by 35 gives the exact quotient by ten.
  localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic pop;
  } sitd_cmd_t;

  typedef struct packed {
    logic more_digits;
    logic last_char;
  } sitd_status_t;

endpackage

// ===== rtl/core/sitd_num_if.sv =====
// Input channel carrying one signed integer per word.
interface sitd_num_if;
  import sitd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/core/sitd_text_if.sv =====
// Output channel carrying one ASCII character per word.
interface sitd_text_if;
  import sitd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== rtl/core/signed_int_to_decimal_ascii_top.sv =====
// Sequence: a load, then a multiply and a divide step per decimal digit, then 1 to 11 output words.
// One value is converted at a time; a new word is taken only after the last character has left.
// Reset (rst, synchronous) returns the controller to idle and drops any text in progress.
// Top level: signed integer to decimal ASCII text, one character per output word.
module signed_int_to_decimal_ascii_top (
  input logic         clk,
  input logic         rst,
  sitd_num_if.sink    num,
  sitd_text_if.source text
);
  import sitd_pkg::*;

  sitd_cmd_t    cmd;
  sitd_status_t status;

  sitd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (num.valid),
    .in_ready  (num.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sitd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (num.value),
    .status    (status),
    .char_code (text.char_code),
    .last_char (text.last_char)
  );

endmodule

// ===== rtl/core/sitd_datapath.sv =====
// Datapath: magnitude register, divide-by-ten step and digit stack.
module sitd_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  sitd_pkg::sitd_cmd_t               cmd,
  input  logic signed [sitd_pkg::VALUE_W-1:0] value,
  output sitd_pkg::sitd_status_t            status,
  output logic [sitd_pkg::CHAR_W-1:0]       char_code,
  output logic                              last_char
);
  import sitd_pkg::*;

  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(MAX_DIGITS - 1);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  logic [VALUE_W-1:0] mag;
  logic [QUOT_W-1:0]  quot;
  logic [DIGIT_W-1:0] stack [MAX_DIGITS];
  logic [CNT_W-1:0]   count;
  logic               sign_pend;

  logic [VALUE_W-1:0] value_u;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quot_ext;
  logic [VALUE_W-1:0] quot_x10;
  logic [VALUE_W-1:0] rem_full;

  assign value_u  = VALUE_W'(value);
  assign prod     = PROD_W'(mag) * PROD_W'(RECIP_TEN);
  assign quot_ext = VALUE_W'(quot);
  assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
  assign rem_full = mag - quot_x10;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sign_pend <= 1'b0;
    end else if (cmd.load) begin
      count     <= '0;
      sign_pend <= value_u[VALUE_W-1];
    end else if (cmd.div) begin
      count <= count + ONE_CNT;
    end else if (cmd.pop) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        count <= count - ONE_CNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;
    end else if (cmd.div) begin
      mag <= quot_ext;
    end
    if (cmd.mul) begin
      quot <= prod[PROD_W-1:RECIP_SH];
    end
  end

  // Digits arrive least significant first; pushing at the bottom leaves the
  // most significant one at the bottom for popping.
  always_ff @(posedge clk) begin
    if (cmd.div) begin
      stack[0] <= rem_full[DIGIT_W-1:0];
      for (int i = 1; i < MAX_DIGITS; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (cmd.pop && !sign_pend) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  assign status.more_digits = (quot != '0) && (count != LAST_SLOT);
  assign status.last_char   = !sign_pend && (count == ONE_CNT);

  assign char_code = sign_pend ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(stack[0]));
  assign last_char = status.last_char;

endmodule

// ===== rtl/core/sitd_ctrl.sv =====
// Controller: sequences loading, digit extraction and character output.
module sitd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  sitd_pkg::sitd_status_t status,
  output sitd_pkg::sitd_cmd_t   cmd
);
  import sitd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_MUL;
      end
      S_MUL: state_next = S_DIV;
      S_DIV: begin
        state_next = status.more_digits ? S_MUL : S_EMIT;
      end
      S_EMIT: begin
        if (out_ready && status.last_char) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

  assign cmd.load = (state == S_IDLE) && in_valid;
  assign cmd.mul  = (state == S_MUL);
  assign cmd.div  = (state == S_DIV);
  assign cmd.pop  = (state == S_EMIT) && out_ready;

endmodule

// ===== tb/signed_int_to_decimal_ascii_top_tb.sv =====
// Testbench for the integer-to-text converter: directed and random values, checked per character.
module signed_int_to_decimal_ascii_top_tb;
  import sitd_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sitd_num_if  num_ch ();
  sitd_text_if text_ch ();

  signed_int_to_decimal_ascii_top uut (
    .clk  (clk),
    .rst  (rst),
    .num  (num_ch),
    .text (text_ch)
  );

  always #5 clk = ~clk;

  // Characters still owed by the block, oldest first.
  text_char_t pending_chars[$];

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned values_sent        = 0;
  int unsigned negatives_sent     = 0;
  int unsigned chars_checked      = 0;
  int unsigned fail_count         = 0;

  // Works out the decimal text of one value and queues its characters.
  task automatic queue_decimal_text(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digits [MAX_DIGITS];
    int                 n_digits;
    text_char_t         ch;
    n_digits = 0;
    // The magnitude is taken modulo 2^32, so the most negative value needs no special path.
    mag = raw[VALUE_W-1] ? (32'd0 - raw) : raw;
    do begin
      digits[n_digits] = DIGIT_W'(mag % 32'd10);
      mag = mag / 32'd10;
      n_digits++;
    end while (mag != 0 && n_digits < MAX_DIGITS);
    if (raw[VALUE_W-1]) begin
      ch.code = CHAR_MINUS;
      ch.last = 1'b0;
      pending_chars.push_back(ch);
    end
    for (int d = n_digits - 1; d >= 0; d--) begin
      ch.code = CHAR_ZERO + CHAR_W'(digits[d]);
      ch.last = (d == 0);
      pending_chars.push_back(ch);
    end
  endtask

  // Offers one value, idling beforehand as the current phase asks, and waits for acceptance.
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      num_ch.valid <= 1'b0;
      num_ch.value <= $urandom;
      @(posedge clk);
    end
    num_ch.valid <= 1'b1;
    num_ch.value <= v;
    @(posedge clk);
    while (!num_ch.ready) @(posedge clk);
    queue_decimal_text(v);
    values_sent++;
    if (v < 0) negatives_sent++;
  endtask

  // Mostly values of a chosen digit count with a random sign, plus raw bit patterns and extreme values.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned       sel;
    int unsigned       n_digits;
    longint unsigned   top;
    longint unsigned   lo;
    logic [VALUE_W-1:0] mag;
    sel = $urandom_range(19);
    if (sel < 4) return $urandom;
    if (sel == 4) begin
      case ($urandom_range(3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    n_digits = $urandom_range(10, 1);
    top = 1;
    repeat (n_digits) top = top * 10;
    lo  = (n_digits > 1) ? top / 10 : 0;
    top = top - 1;
    if (top > 64'd2147483647) top = 64'd2147483647;
    mag = $urandom_range(top[31:0], lo[31:0]);
    return $urandom_range(1) ? -$signed(mag) : $signed(mag);
  endfunction

  task automatic send_random_values(input int unsigned n);
    repeat (n) send_value(pick_value());
  endtask

  task automatic test_directed_values();
    int probes[$] = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -101, 12345, -67890,
                      999999999, 1000000000, -1000000000, 2147483647, -2147483647,
                      32'sh8000_0000, 1234567890, -1987654321,
                      32'sh5555_5555, 32'hAAAA_AAAA};
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    foreach (probes[i]) send_value(probes[i]);
  endtask

  task automatic test_steady_stream();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_random_values(80);
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct    = 82;
    receiver_stall_pct = 0;
    send_random_values(80);
  endtask

  task automatic test_receiver_stalls();
    sender_idle_pct    = 0;
    receiver_stall_pct = 82;
    send_random_values(80);
  endtask

  task automatic test_light_pressure_both();
    sender_idle_pct    = 8;
    receiver_stall_pct = 8;
    send_random_values(80);
  endtask

  always @(posedge clk) begin
    text_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Compares every character that leaves with the oldest one owed.
  always @(posedge clk) begin
    text_char_t got;
    text_char_t want;
    if (!rst && text_ch.valid && text_ch.ready) begin
      got.code = text_ch.char_code;
      got.last = text_ch.last_char;
      if (pending_chars.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Unexpected word: char_code %0d last_char %0b", got.code, got.last);
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (got.code !== want.code || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Mismatch: expected char_code %0d ('%c') last_char %0b, got %0d last_char %0b",
                     want.code, 8'(want.code), want.last, got.code, got.last);
        end
      end
    end
  end

  initial begin
    num_ch.valid  = 1'b0;
    num_ch.value  = '0;
    text_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_values();
    test_steady_stream();
    test_sender_gaps();
    test_receiver_stalls();
    test_light_pressure_both();

    num_ch.valid       <= 1'b0;
    receiver_stall_pct = 0;
    while (pending_chars.size() != 0) @(posedge clk);
    // Allow for any stray words the block might still emit.
    repeat (40) @(posedge clk);

    $display("Converted %0d integers (%0d negative) into %0d checked characters.",
             values_sent, negatives_sent, chars_checked);
    $display("Pacing: free stream, sender gaps, receiver stalls, light load; %0d failures.",
             fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d characters still owed.", pending_chars.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sitd_pkg.sv
rtl/core/sitd_num_if.sv
rtl/core/sitd_text_if.sv
rtl/core/sitd_datapath.sv
rtl/core/sitd_ctrl.sv
rtl/core/signed_int_to_decimal_ascii_top.sv
tb/signed_int_to_decimal_ascii_top_tb.sv
